// File: src/scbp_pkg.sv
// ----------------------------------------------------------------------------
// Size-class buffer pool package
// Shared sizes, codes, record types and helper functions of the pool.
// ----------------------------------------------------------------------------
`default_nettype none

package scbp_pkg;

    localparam int SIZE_CLASSES    = 16;
    localparam int SLOTS_PER_CLASS = 8;

    localparam int CLASS_W  = $clog2(SIZE_CLASSES);
    localparam int SLOT_W   = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
    localparam int CNT_W    = $clog2(SLOTS_PER_CLASS + 1);
    localparam int HADDR_W  = (SIZE_CLASSES * SLOTS_PER_CLASS > 1)
                              ? $clog2(SIZE_CLASSES * SLOTS_PER_CLASS) : 1;
    localparam int PADDR_W  = 3;

    // Commands.
    localparam logic [1:0] CMD_BEGIN_FRAME = 2'd0;
    localparam logic [1:0] CMD_REQUEST     = 2'd1;
    localparam logic [1:0] CMD_STATS       = 2'd2;
    localparam logic [1:0] CMD_DEPTH       = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NEW  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Register indexes (byte address bit 2).
    localparam logic REG_MIN_EXP = 1'b0;
    localparam logic REG_MAX_EXP = 1'b1;

    typedef struct packed {
        logic [3:0] min_exponent;
        logic [3:0] max_exponent;
    } cfg_t;

    typedef struct packed {
        logic [15:0]        qsize;
        logic [CLASS_W-1:0] cls;
    } quant_t;

    // One class entry of the class memory.
    typedef struct packed {
        logic [SLOTS_PER_CLASS-1:0] used;
        logic [CNT_W-1:0]           count;
        logic                       depth_present;
        logic [3:0]                 depth_handle;
    } class_entry_t;

    // Exponent reduced modulo the number of classes by repeated subtraction.
    function automatic logic [CLASS_W-1:0] class_of(input logic [3:0] e);
        logic [5:0] r;
        r = {2'b00, e};
        for (int i = 0; i < 8; i++)
        begin
            if (r >= 6'(SIZE_CLASSES))
            begin
                r = r - 6'(SIZE_CLASSES);
            end
        end
        return CLASS_W'(r);
    endfunction

    // Count reduced to the 4-bit width of the result fields.
    function automatic logic [3:0] count_nibble(input logic [CNT_W-1:0] n);
        logic [CNT_W+3:0] t;
        t = {4'b0000, n};
        return t[3:0];
    endfunction

endpackage

`default_nettype wire

// File: src/scbp_if.sv
// ----------------------------------------------------------------------------
// Size-class buffer pool channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface scbp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] requested_size;

    modport source (output valid, output command, output requested_size, input ready);
    modport sink   (input valid, input command, input requested_size, output ready);
endinterface

interface scbp_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] quantized_size;
    logic [6:0]  buffer_id;
    logic [3:0]  depth_id;
    logic [1:0]  status;
    logic [3:0]  active_count;
    logic [3:0]  total_count;

    modport source (output valid, output quantized_size, output buffer_id,
                    output depth_id, output status, output active_count,
                    output total_count, input ready);
    modport sink   (input valid, input quantized_size, input buffer_id,
                    input depth_id, input status, input active_count,
                    input total_count, output ready);
endinterface

`default_nettype wire

// File: src/size_class_buffer_pool_top.sv
// ----------------------------------------------------------------------------
// Size-class buffer pool top level
// Buffer allocator grouped by power-of-two size classes, with depth handles.
// ----------------------------------------------------------------------------
// Each command word is taken only in the idle state and passes through the class
// memory read at the accept, the modify and write-back step that also reads the
// handle memory, and the output load before the next word is taken. A result
// still held by a stalled consumer delays the load.
// Reset (rst_n, asynchronous, active low) clears all classes, the frame marks,
// both handle counters and the registers to floor 7 and ceiling 11 at once.
`default_nettype none

module size_class_buffer_pool_top
    import scbp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    scbp_req_if.sink                req_ch,
    scbp_rsp_if.source              rsp_ch
);

    cfg_t   cfg;
    quant_t quant;

    // Floor/ceiling registers: written by user only while pool idle; unenforced.
    scbp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The incoming size is quantized in the cycle the word is taken, so the
    // class address goes straight to the class memory read port.
    scbp_quant u_quant (
        .requested_size (req_ch.requested_size),
        .cfg            (cfg),
        .quant          (quant)
    );

    // The engine keeps per-class state in one memory and buffer handles in
    // another, and holds the result word until the consumer takes it.
    scbp_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .quant  (quant),
        .req_ch (req_ch),
        .rsp_ch (rsp_ch)
    );

endmodule

`default_nettype wire

// File: src/scbp_apb_regs.sv
// ----------------------------------------------------------------------------
// Size-class buffer pool register file
// APB-style access to the exponent floor and ceiling registers.
// ----------------------------------------------------------------------------
`default_nettype none

module scbp_apb_regs
    import scbp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    logic [3:0] min_exp_reg;
    logic [3:0] max_exp_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_exp_reg <= 4'd7;
            max_exp_reg <= 4'd11;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_MIN_EXP: min_exp_reg <= pwdata[3:0];
                REG_MAX_EXP: max_exp_reg <= pwdata[3:0];
                default:     min_exp_reg <= min_exp_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MIN_EXP: prdata = {28'd0, min_exp_reg};
            REG_MAX_EXP: prdata = {28'd0, max_exp_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign cfg.min_exponent = min_exp_reg;
    assign cfg.max_exponent = max_exp_reg;

endmodule

`default_nettype wire

// File: src/scbp_quant.sv
// ----------------------------------------------------------------------------
// Size-class buffer pool size quantizer
// Rounds a size down to a power of two, clamps the exponent, picks the class.
// ----------------------------------------------------------------------------
`default_nettype none

module scbp_quant
    import scbp_pkg::*;
(
    input  wire logic [15:0] requested_size,
    input  cfg_t             cfg,
    output quant_t           quant
);

    logic [3:0] msb;
    logic [3:0] exp_clamped;
    logic       below;

    // Leading-one position; a zero size counts as below the floor.
    always_comb
    begin
        msb = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (requested_size[i])
            begin
                msb = 4'(i);
            end
        end
    end

    // The floor test has priority over the ceiling test.
    always_comb
    begin
        below = (requested_size == 16'd0) || (msb < cfg.min_exponent);
        priority if (below)
        begin
            exp_clamped = cfg.min_exponent;
        end
        else if (msb > cfg.max_exponent)
        begin
            exp_clamped = cfg.max_exponent;
        end
        else
        begin
            exp_clamped = msb;
        end
    end

    assign quant.qsize = 16'd1 << exp_clamped;
    assign quant.cls   = class_of(exp_clamped);

endmodule

`default_nettype wire

// File: src/scbp_engine.sv
// ----------------------------------------------------------------------------
// Size-class buffer pool engine
// Class memory read-modify-write, handle memory and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scbp_engine
    import scbp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  quant_t      quant,
    scbp_req_if.sink    req_ch,
    scbp_rsp_if.source  rsp_ch
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Memories.
    class_entry_t class_mem [SIZE_CLASSES];
    logic [6:0]   handle_mem [SIZE_CLASSES * SLOTS_PER_CLASS];
    class_entry_t class_rd_reg;
    logic [6:0]   handle_rd_reg;

    // Per-class valid bits: known clears only at reset, frame also at begin frame.
    logic [SIZE_CLASSES-1:0] known_reg;
    logic [SIZE_CLASSES-1:0] frame_reg;

    logic [7:0] next_buf_reg;
    logic [4:0] next_dep_reg;

    // Item being worked on.
    logic [1:0]         cmd_reg;
    logic [15:0]        qsize_reg;
    logic [CLASS_W-1:0] cls_reg;

    // Result held between the modify and output steps.
    logic [6:0] res_buf_reg;
    logic [3:0] res_dep_reg;
    logic [1:0] res_status_reg;
    logic [3:0] res_act_reg;
    logic [3:0] res_tot_reg;
    logic       from_mem_reg;

    // Output register.
    logic        out_valid_reg;
    logic [15:0] out_qsize_reg;
    logic [6:0]  out_buf_reg;
    logic [3:0]  out_dep_reg;
    logic [1:0]  out_status_reg;
    logic [3:0]  out_act_reg;
    logic [3:0]  out_tot_reg;

    logic accept;
    logic out_load;

    // Modify step.
    class_entry_t               cur;
    class_entry_t               entry_next;
    logic [SLOTS_PER_CLASS-1:0] free_mask;
    logic                       found;
    logic [SLOT_W-1:0]          slot_sel;
    logic                       full;
    logic [CNT_W-1:0]           act_next;
    logic                       cwr_en;
    logic                       hwr_en;
    logic                       hrd_en;
    logic [HADDR_W-1:0]         haddr;
    logic [6:0]                 res_buf_next;
    logic [3:0]                 res_dep_next;
    logic [1:0]                 res_status_next;
    logic [7:0]                 next_buf_next;
    logic [4:0]                 next_dep_next;

    assign req_ch.ready = (state_reg == S_IDLE);
    assign accept       = req_ch.valid && req_ch.ready;
    assign out_load     = (state_reg == S_OUT) && (!out_valid_reg || rsp_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_MOD;
            S_MOD:   state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Effective class entry after the valid bits are applied.
    always_comb
    begin
        cur = class_rd_reg;
        if (!known_reg[cls_reg])
        begin
            cur.count         = '0;
            cur.depth_present = 1'b0;
        end
        if (!(known_reg[cls_reg] && frame_reg[cls_reg]))
        begin
            cur.used = '0;
        end
    end

    // Lowest free slot among the created ones.
    always_comb
    begin
        for (int i = 0; i < SLOTS_PER_CLASS; i++)
        begin
            free_mask[i] = (CNT_W'(i) < cur.count) && !cur.used[i];
        end
        found    = 1'b0;
        slot_sel = '0;
        for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                found    = 1'b1;
                slot_sel = SLOT_W'(i);
            end
        end
        full = (cur.count == CNT_W'(SLOTS_PER_CLASS));
        if (!found)
        begin
            slot_sel = SLOT_W'(cur.count);
        end
    end

    assign haddr = HADDR_W'(cls_reg) * HADDR_W'(SLOTS_PER_CLASS) + HADDR_W'(slot_sel);

    always_comb
    begin
        entry_next      = cur;
        cwr_en          = 1'b0;
        hwr_en          = 1'b0;
        hrd_en          = 1'b0;
        res_buf_next    = 7'd0;
        res_dep_next    = 4'd0;
        res_status_next = ST_DONE;
        next_buf_next   = next_buf_reg;
        next_dep_next   = next_dep_reg;
        if (state_reg == S_MOD)
        begin
            unique case (cmd_reg)
                CMD_REQUEST:
                begin
                    priority if (found)
                    begin
                        entry_next.used[slot_sel] = 1'b1;
                        cwr_en = 1'b1;
                        hrd_en = 1'b1;
                    end
                    else if (full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        entry_next.used[slot_sel] = 1'b1;
                        entry_next.count          = cur.count + CNT_W'(1);
                        res_buf_next              = next_buf_reg[6:0];
                        res_status_next           = ST_NEW;
                        next_buf_next             = next_buf_reg + 8'd1;
                        cwr_en                    = 1'b1;
                        hwr_en                    = 1'b1;
                    end
                end
                CMD_DEPTH:
                begin
                    if (cur.depth_present)
                    begin
                        res_dep_next = cur.depth_handle;
                    end
                    else
                    begin
                        entry_next.depth_present = 1'b1;
                        entry_next.depth_handle  = next_dep_reg[3:0];
                        res_dep_next             = next_dep_reg[3:0];
                        res_status_next          = ST_NEW;
                        next_dep_next            = next_dep_reg + 5'd1;
                        cwr_en                   = 1'b1;
                    end
                end
                default:
                begin
                    cwr_en = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        act_next = '0;
        for (int i = 0; i < SLOTS_PER_CLASS; i++)
        begin
            act_next = act_next + CNT_W'(entry_next.used[i]);
        end
    end

    // Class memory: read at accept, written back in the modify step.
    always_ff @(posedge clk)
    begin
        if (cwr_en)
        begin
            class_mem[cls_reg] <= entry_next;
        end
        if (accept)
        begin
            class_rd_reg <= class_mem[quant.cls];
        end
    end

    // Handle memory: at most one write or one read per item, on requests only.
    always_ff @(posedge clk)
    begin
        if (hwr_en)
        begin
            handle_mem[haddr] <= next_buf_reg[6:0];
        end
        if (hrd_en)
        begin
            handle_rd_reg <= handle_mem[haddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            known_reg     <= '0;
            frame_reg     <= '0;
            next_buf_reg  <= 8'd0;
            next_dep_reg  <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            next_buf_reg <= next_buf_next;
            next_dep_reg <= next_dep_next;
            if ((state_reg == S_MOD) && (cmd_reg == CMD_BEGIN_FRAME))
            begin
                frame_reg <= '0;
            end
            else if (cwr_en)
            begin
                known_reg[cls_reg] <= 1'b1;
                frame_reg[cls_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req_ch.command;
            qsize_reg <= quant.qsize;
            cls_reg   <= quant.cls;
        end
        if (state_reg == S_MOD)
        begin
            res_buf_reg    <= res_buf_next;
            res_dep_reg    <= res_dep_next;
            res_status_reg <= res_status_next;
            from_mem_reg   <= hrd_en;
            if ((cmd_reg == CMD_REQUEST) || (cmd_reg == CMD_STATS))
            begin
                res_act_reg <= count_nibble(act_next);
                res_tot_reg <= count_nibble(entry_next.count);
            end
            else
            begin
                res_act_reg <= 4'd0;
                res_tot_reg <= 4'd0;
            end
        end
        if (out_load)
        begin
            out_qsize_reg  <= (cmd_reg == CMD_BEGIN_FRAME) ? 16'd0 : qsize_reg;
            out_buf_reg    <= from_mem_reg ? handle_rd_reg : res_buf_reg;
            out_dep_reg    <= res_dep_reg;
            out_status_reg <= res_status_reg;
            out_act_reg    <= res_act_reg;
            out_tot_reg    <= res_tot_reg;
        end
    end

    assign rsp_ch.valid          = out_valid_reg;
    assign rsp_ch.quantized_size = out_qsize_reg;
    assign rsp_ch.buffer_id      = out_buf_reg;
    assign rsp_ch.depth_id       = out_dep_reg;
    assign rsp_ch.status         = out_status_reg;
    assign rsp_ch.active_count   = out_act_reg;
    assign rsp_ch.total_count    = out_tot_reg;

endmodule

`default_nettype wire

// File: src/scbp_checker.sv
// ----------------------------------------------------------------------------
// Size-class buffer pool checker
// Port-level properties of result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scbp_checker
    import scbp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [15:0] quantized_size,
    input wire logic [6:0]  buffer_id,
    input wire logic [3:0]  depth_id,
    input wire logic [1:0]  status,
    input wire logic [3:0]  active_count,
    input wire logic [3:0]  total_count
);

    // A full class grants nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL) |-> (buffer_id == 7'd0) && (depth_id == 4'd0))
    else $error("pool full result carries a handle");

    // The quantized size is zero or a single power of two.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0(quantized_size))
    else $error("quantized size is not a power of two");

    // A class never has more buffers in use than it has created.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (active_count <= total_count))
    else $error("active count exceeds total count");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(buffer_id) && $stable(status))
    else $error("stalled result word changed");

endmodule

bind size_class_buffer_pool_top scbp_checker u_scbp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp_ch.valid),
    .rsp_ready      (rsp_ch.ready),
    .quantized_size (rsp_ch.quantized_size),
    .buffer_id      (rsp_ch.buffer_id),
    .depth_id       (rsp_ch.depth_id),
    .status         (rsp_ch.status),
    .active_count   (rsp_ch.active_count),
    .total_count    (rsp_ch.total_count)
);

`default_nettype wire

// File: tb/tb_size_class_buffer_pool_top.sv
// ----------------------------------------------------------------------------
// Size-class buffer pool testbench
// Drives command words into the pool and configures the clamp registers over
// APB. A scoreboard predicts every result word from its own model of the
// classes, frame marks and handle counters, and checks each field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_size_class_buffer_pool_top
    import scbp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // The run is ended by the watchdog if it has not finished by this cycle.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_WORDS  = 280;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_PRINTED  = 40;

    // One result word as the pool should produce it.
    typedef struct packed {
        logic [15:0] qsize;
        logic [6:0]  buf_id;
        logic [3:0]  dep_id;
        logic [1:0]  status;
        logic [3:0]  active;
        logic [3:0]  total;
    } pool_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds a private model of the pool and the queue of result
    // words still owed by the block.
    // ------------------------------------------------------------------------
    class pool_scoreboard;
        logic [3:0]                 floor_exp;
        logic [3:0]                 ceil_exp;
        logic [SLOTS_PER_CLASS-1:0] in_use [SIZE_CLASSES];
        logic [3:0]                 created [SIZE_CLASSES];
        logic [6:0]                 buf_handle [SIZE_CLASSES][SLOTS_PER_CLASS];
        logic [7:0]                 next_buf;
        bit                         has_depth [SIZE_CLASSES];
        logic [3:0]                 depth_hdl [SIZE_CLASSES];
        logic [4:0]                 next_depth;
        pool_result_t               owed [$];
        int                         errors;

        function new();
            floor_exp  = 4'd7;
            ceil_exp   = 4'd11;
            next_buf   = '0;
            next_depth = '0;
            errors     = 0;
            for (int c = 0; c < SIZE_CLASSES; c++)
            begin
                in_use[c]    = '0;
                created[c]   = '0;
                has_depth[c] = 1'b0;
                depth_hdl[c] = '0;
                for (int s = 0; s < SLOTS_PER_CLASS; s++)
                begin
                    buf_handle[c][s] = '0;
                end
            end
        endfunction

        function void report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endfunction

        function void set_register(int idx, logic [3:0] value);
            if (idx == int'(REG_MIN_EXP))
            begin
                floor_exp = value;
            end
            else
            begin
                ceil_exp = value;
            end
        endfunction

        // Power-of-two exponent of the size, with the floor test made first.
        function logic [3:0] clamp_exp(logic [15:0] size);
            logic [3:0] msb;
            msb = '0;
            for (int b = 0; b < 16; b++)
            begin
                if (size[b])
                begin
                    msb = 4'(b);
                end
            end
            if (size == 16'd0 || msb < floor_exp)
            begin
                return floor_exp;
            end
            else if (msb > ceil_exp)
            begin
                return ceil_exp;
            end
            return msb;
        endfunction

        function void note_command(logic [1:0] cmd, logic [15:0] size);
            logic [3:0]   e;
            int           cls;
            int           slot;
            bit           hit;
            pool_result_t r;
            e     = clamp_exp(size);
            cls   = int'(e) % SIZE_CLASSES;
            r     = '0;
            r.qsize = 16'd1 << e;
            hit   = 1'b0;
            case (cmd)
                CMD_BEGIN_FRAME:
                begin
                    for (int c = 0; c < SIZE_CLASSES; c++)
                    begin
                        in_use[c] = '0;
                    end
                    r.qsize = '0;
                end
                CMD_REQUEST:
                begin
                    for (slot = 0; slot < int'(created[cls]) && slot < SLOTS_PER_CLASS;
                         slot++)
                    begin
                        if (!hit && !in_use[cls][slot])
                        begin
                            in_use[cls][slot] = 1'b1;
                            r.buf_id = buf_handle[cls][slot];
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                    begin
                        if (int'(created[cls]) >= SLOTS_PER_CLASS)
                        begin
                            r.status = ST_FULL;
                        end
                        else
                        begin
                            slot = int'(created[cls]);
                            buf_handle[cls][slot] = next_buf[6:0];
                            r.buf_id = next_buf[6:0];
                            in_use[cls][slot] = 1'b1;
                            created[cls] = created[cls] + 4'd1;
                            next_buf = next_buf + 8'd1;
                            r.status = ST_NEW;
                        end
                    end
                    r.active = 4'($countones(in_use[cls]));
                    r.total  = created[cls];
                end
                CMD_STATS:
                begin
                    r.active = 4'($countones(in_use[cls]));
                    r.total  = created[cls];
                end
                default:
                begin
                    if (has_depth[cls])
                    begin
                        r.dep_id = depth_hdl[cls];
                    end
                    else
                    begin
                        r.dep_id       = next_depth[3:0];
                        depth_hdl[cls] = next_depth[3:0];
                        has_depth[cls] = 1'b1;
                        next_depth     = next_depth + 5'd1;
                        r.status       = ST_NEW;
                    end
                end
            endcase
            owed.insert(owed.size(), r);
        endfunction

        function void check_result(pool_result_t got);
            pool_result_t want;
            if (owed.size() == 0)
            begin
                report_mismatch("result word with nothing expected");
                return;
            end
            want = owed.pop_front();
            if (got.qsize != want.qsize)
                report_mismatch($sformatf("quantized_size %0d, want %0d",
                                          got.qsize, want.qsize));
            if (got.buf_id != want.buf_id)
                report_mismatch($sformatf("buffer_id %0d, want %0d",
                                          got.buf_id, want.buf_id));
            if (got.dep_id != want.dep_id)
                report_mismatch($sformatf("depth_id %0d, want %0d",
                                          got.dep_id, want.dep_id));
            if (got.status != want.status)
                report_mismatch($sformatf("status %0d, want %0d",
                                          got.status, want.status));
            if (got.active != want.active)
                report_mismatch($sformatf("active_count %0d, want %0d",
                                          got.active, want.active));
            if (got.total != want.total)
                report_mismatch($sformatf("total_count %0d, want %0d",
                                          got.total, want.total));
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block and channels.
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    scbp_req_if req_ch();
    scbp_rsp_if rsp_ch();

    pool_scoreboard sb;

    // Flags shared between the stimulus, the receiver and the long hold-off.
    bit hold_arm;
    bit rsp_hold;
    int cycles;

    size_class_buffer_pool_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req_ch  (req_ch),
        .rsp_ch  (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Idle lengths: half of them zero, most of the rest short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Result side. The ready line changes on the falling edge; a long hold-off
    // from its own process overrides everything so that the block backs up.
    // Between short stalls there are calm stretches in which ready stays high.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int calm_left;
        bit calm;
        stall_left   = 0;
        calm_left    = 64;
        calm         = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            calm_left--;
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(32, 128);
            end
            if (rsp_hold)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // The long hold-off: once armed, the receiver refuses result words for a
    // fixed stretch of cycles while the sender keeps offering command words.
    initial
    begin
        rsp_hold = 1'b0;
        wait (hold_arm);
        @(posedge clk);
        rsp_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_hold = 1'b0;
    end

    // Every accepted result word goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            sb.check_result('{qsize:  rsp_ch.quantized_size,
                              buf_id: rsp_ch.buffer_id,
                              dep_id: rsp_ch.depth_id,
                              status: rsp_ch.status,
                              active: rsp_ch.active_count,
                              total:  rsp_ch.total_count});
        end
    end

    // Watchdog: a run that overstays the limit is a failure.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------------

    // A register write, setup then access, followed by a read-back of the
    // same register. psel stays high from the write into the read setup.
    task automatic write_register(input int idx, input logic [3:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata != 32'(value))
        begin
            sb.report_mismatch($sformatf("register %0d reads %0h, want %0h",
                                         idx, prdata, value));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offers one command word, waits for it to be taken, then idles for a
    // random gap unless the sender is in a calm stretch. With no gap, valid
    // simply stays high into the next word.
    task automatic send_word(input logic [1:0] cmd, input logic [15:0] size,
                             input bit calm);
        int gap;
        @(negedge clk);
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.requested_size <= size;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sb.note_command(cmd, size);
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Lets every owed result word arrive, then a few more cycles so that
    // nothing is in flight when the registers change or the run ends.
    task automatic drain_pool();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Mostly well-formed power-of-two sizes with random low bits, so that all
    // exponents are hit evenly; a few zero and fully random sizes as well.
    function automatic logic [15:0] rand_size();
        int         r;
        logic [3:0] e;
        logic [15:0] top;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            return 16'd0;
        end
        else if (r < 14)
        begin
            return 16'($urandom);
        end
        e   = 4'($urandom_range(0, 15));
        top = 16'd1 << e;
        return top | (16'($urandom) & (top - 16'd1));
    endfunction

    // Requests dominate so that classes fill up; begin-frame is kept rare so
    // that reuse and the full case both get exercised between frames.
    function automatic logic [1:0] rand_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            return CMD_BEGIN_FRAME;
        end
        else if (r < 60)
        begin
            return CMD_REQUEST;
        end
        else if (r < 78)
        begin
            return CMD_STATS;
        end
        return CMD_DEPTH;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [3:0] floors [6];
        logic [3:0] ceils  [6];
        bit         calm;

        sb       = new();
        hold_arm = 1'b0;
        calm     = 1'b0;

        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_BEGIN_FRAME;
        req_ch.requested_size = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset clamp of 7 to 11.
        send_word(CMD_STATS,       16'd0,     calm); // zero size lands on the floor
        send_word(CMD_REQUEST,     16'd0,     calm); // first buffer ever gets handle 0
        send_word(CMD_REQUEST,     16'hFFFF,  calm); // clamped to the ceiling
        send_word(CMD_REQUEST,     16'd128,   calm);
        send_word(CMD_STATS,       16'd200,   calm);
        send_word(CMD_DEPTH,       16'd1,     calm); // first depth handle is 0
        send_word(CMD_DEPTH,       16'd1500,  calm);
        send_word(CMD_DEPTH,       16'd0,     calm); // existing depth handle
        send_word(CMD_BEGIN_FRAME, 16'hFFFF,  calm);
        send_word(CMD_REQUEST,     16'd130,   calm); // reuse after the frame mark
        send_word(CMD_REQUEST,     16'd255,   calm);
        send_word(CMD_REQUEST,     16'd129,   calm);
        // Fill the ceiling class to its last slot and one past it.
        repeat (9)
        begin
            send_word(CMD_REQUEST, 16'd2048, calm);
        end
        send_word(CMD_STATS,       16'hFFFF,  calm);
        send_word(CMD_BEGIN_FRAME, 16'd0,     calm);
        send_word(CMD_STATS,       16'd2048,  calm);
        drain_pool();

        // Random phases: the widest clamp first so that every class fills,
        // then the floor above the ceiling, both single-class extremes, a
        // middle setting and a random one.
        floors = '{4'd0,  4'd15, 4'd0, 4'd15, 4'd3, 4'($urandom_range(0, 15))};
        ceils  = '{4'd15, 4'd0,  4'd0, 4'd15, 4'd9, 4'($urandom_range(0, 15))};
        for (int p = 0; p < 6; p++)
        begin
            write_register(int'(REG_MIN_EXP), floors[p]);
            write_register(int'(REG_MAX_EXP), ceils[p]);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % 100 == 0)
                begin
                    calm = ($urandom_range(0, 3) == 0);
                end
                // Start the long receiver hold-off early in the first phase.
                if (p == 0 && n == 40)
                begin
                    hold_arm = 1'b1;
                end
                send_word(rand_command(), rand_size(), calm);
            end
            drain_pool();
        end

        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d result words never arrived",
                                         sb.pending()));
        end

        if (sb.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
